/* design/sound_level_meter_bands_unit_macros.svh */
// ----------------------------------------------------------------------------
// Sound level meter bands unit: assertion macros
// Concurrent assertion forms used by the slmb_back sequencer.
// ----------------------------------------------------------------------------
`ifndef SOUND_LEVEL_METER_BANDS_UNIT_MACROS_SVH
`define SOUND_LEVEL_METER_BANDS_UNIT_MACROS_SVH

// same-cycle implication
`define SLMB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLMB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/slmb_pkg.sv */
// ----------------------------------------------------------------------------
// slmb_pkg
// Types and constants shared by the sound level meter bands unit.
// ----------------------------------------------------------------------------
`default_nettype none

package slmb_pkg;

    localparam int NUM_BANDS       = 8;
    localparam int BAND_W          = 3;
    localparam int SAMPLE_BITS     = 24;
    localparam int PWR_W           = 48;
    localparam int PWR_FRAC        = 46;
    localparam int PWR_SHIFT       = 2 * (SAMPLE_BITS - 1) - PWR_FRAC;
    localparam int DB_PER_LOG2_Q16 = 197283;
    localparam int LEVEL_W         = 16;
    localparam int COUNT_W         = 32;
    localparam int PHASE_W         = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_DS_FACTOR      = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_LOWPASS_ENABLE = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_LOWPASS_B0     = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_LOWPASS_A1     = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] REG_REF_OFFSET_DB  = CFG_ADDR_W'(4);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef logic [PWR_W-1:0]          power_t;
    typedef logic signed [LEVEL_W-1:0] level_t;

    typedef struct packed {
        logic [15:0]        ds_factor;
        logic               lowpass_enable;
        logic [30:0]        lowpass_b0;
        logic signed [31:0] lowpass_a1;
        logic signed [15:0] ref_offset_db;
    } cfg_t;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic              band_ok;
        power_t            power;
    } item_t;

    typedef struct packed {
        logic [BAND_W-1:0] band_out;
        logic              emitted;
        level_t            level;
        level_t            peak_level;
        level_t            max_level;
        level_t            eq_level;
    } result_t;

endpackage

`default_nettype wire

/* design/sound_level_meter_bands_unit.sv */
// ----------------------------------------------------------------------------
// sound_level_meter_bands_unit
// Multi-band sound level meter with exponential time weighting and dB levels.
// ----------------------------------------------------------------------------
//  channel  | ports                          | transaction
//  ---------+--------------------------------+-------------------------------
//  input    | s_valid/s_ready, s_band/sample | one band-filtered sample
//  result   | m_valid/m_ready, m_*           | band, emitted flag, 4 levels
//  config   | cfg_we, cfg_addr, cfg_wdata    | one register write, no wait
//
//  Items run one at a time through the sequencer; the log unit (six normalise
//  steps and sixteen squarings per level) dominates the time per item, and an
//  item takes longer with the lowpass on and at a decimation point (48-step
//  mean divider and the extra level). An invalid band goes straight to the result.
//  Reset is synchronous and clears all per-band state at once.
//  A stalled result is held in the output register; the input stage and a
//  two-entry queue keep taking transactions meanwhile, until the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sound_level_meter_bands_unit (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_we,
    input  logic [slmb_pkg::CFG_ADDR_W-1:0]          cfg_addr,
    input  logic [slmb_pkg::CFG_DATA_W-1:0]          cfg_wdata,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [slmb_pkg::BAND_W-1:0]              s_band,
    input  logic signed [slmb_pkg::SAMPLE_BITS-1:0]  s_sample,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [slmb_pkg::BAND_W-1:0]              m_band_out,
    output logic                                     m_emitted,
    output logic signed [slmb_pkg::LEVEL_W-1:0]      m_level,
    output logic signed [slmb_pkg::LEVEL_W-1:0]      m_peak_level,
    output logic signed [slmb_pkg::LEVEL_W-1:0]      m_max_level,
    output logic signed [slmb_pkg::LEVEL_W-1:0]      m_eq_level
);

    slmb_pkg::cfg_t    cfg_reg, cfg_next;
    logic              q_push, q_full, q_pop, q_valid;
    slmb_pkg::item_t   push_item, pop_item;
    logic              log_start, log_done;
    slmb_pkg::power_t  log_value;
    slmb_pkg::level_t  log_result;
    slmb_pkg::result_t result;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                slmb_pkg::REG_DS_FACTOR:      cfg_next.ds_factor      = cfg_wdata[15:0];
                slmb_pkg::REG_LOWPASS_ENABLE: cfg_next.lowpass_enable = cfg_wdata[0];
                slmb_pkg::REG_LOWPASS_B0:     cfg_next.lowpass_b0     = cfg_wdata[30:0];
                slmb_pkg::REG_LOWPASS_A1:     cfg_next.lowpass_a1     = cfg_wdata[31:0];
                slmb_pkg::REG_REF_OFFSET_DB:  cfg_next.ref_offset_db  = cfg_wdata[15:0];
                default:                      cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ds_factor      <= 16'd1;
            cfg_reg.lowpass_enable <= 1'b0;
            cfg_reg.lowpass_b0     <= 31'h4000_0000;
            cfg_reg.lowpass_a1     <= '0;
            cfg_reg.ref_offset_db  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    slmb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_band   (s_band),
        .s_sample (s_sample),
        .q_push   (q_push),
        .q_item   (push_item),
        .q_full   (q_full)
    );

    slmb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (pop_item)
    );

    slmb_log u_log (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (log_start),
        .value         (log_value),
        .ref_offset_db (cfg_reg.ref_offset_db),
        .done          (log_done),
        .result        (log_result)
    );

    slmb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (pop_item),
        .q_pop      (q_pop),
        .log_start  (log_start),
        .log_value  (log_value),
        .log_done   (log_done),
        .log_result (log_result),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (result)
    );

    assign m_band_out   = result.band_out;
    assign m_emitted    = result.emitted;
    assign m_level      = result.level;
    assign m_peak_level = result.peak_level;
    assign m_max_level  = result.max_level;
    assign m_eq_level   = result.eq_level;

endmodule

`default_nettype wire

/* design/slmb_front.sv */
// ----------------------------------------------------------------------------
// slmb_front
// Input stage: takes a transaction, checks the band and squares the sample.
// ----------------------------------------------------------------------------
`default_nettype none

module slmb_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [slmb_pkg::BAND_W-1:0]            s_band,
    input  logic signed [slmb_pkg::SAMPLE_BITS-1:0] s_sample,
    output logic                                   q_push,
    output slmb_pkg::item_t                        q_item,
    input  logic                                   q_full
);

    localparam int SB   = slmb_pkg::SAMPLE_BITS;
    localparam int R_SH = (slmb_pkg::PWR_SHIFT >= 0) ? slmb_pkg::PWR_SHIFT : 0;
    localparam int L_SH = (slmb_pkg::PWR_SHIFT < 0) ? -slmb_pkg::PWR_SHIFT : 0;

    logic                        stg_valid_reg, stg_valid_next;
    logic [slmb_pkg::BAND_W-1:0] stg_band_reg;
    logic                        stg_ok_reg;
    logic [SB-1:0]               stg_mag_reg;
    logic [SB-1:0]               raw;
    logic [SB-1:0]               mag_in;
    logic [2*SB-1:0]             sq;
    logic [63:0]                 pwr64;
    logic                        accept;

    assign q_push  = stg_valid_reg && !q_full;
    assign s_ready = !stg_valid_reg || !q_full;
    assign accept  = s_valid && s_ready;

    assign raw    = s_sample;
    assign mag_in = raw[SB-1] ? (~raw + SB'(1)) : raw;

    assign sq    = stg_mag_reg * stg_mag_reg;
    assign pwr64 = (64'(sq) >> R_SH) << L_SH;

    assign q_item.band    = stg_band_reg;
    assign q_item.band_ok = stg_ok_reg;
    assign q_item.power   = pwr64[slmb_pkg::PWR_W-1:0];

    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (accept) begin
            stg_valid_next = 1'b1;
        end else if (q_push) begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_band_reg <= s_band;
            stg_ok_reg   <= (32'(s_band) < slmb_pkg::NUM_BANDS);
            stg_mag_reg  <= mag_in;
        end
    end

endmodule

`default_nettype wire

/* design/slmb_queue.sv */
// ----------------------------------------------------------------------------
// slmb_queue
// Short queue between the input stage and the processing sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module slmb_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  slmb_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output slmb_pkg::item_t pop_item
);

    localparam int PW = slmb_pkg::QPTR_W;

    slmb_pkg::item_t mem_reg [slmb_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;
    logic            do_push, do_pop;

    assign full     = (count_reg == (PW+1)'(slmb_pkg::QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(slmb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(slmb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + (PW+1)'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* design/slmb_log.sv */
// ----------------------------------------------------------------------------
// slmb_log
// Iterative dB converter: 10*log10((P+1)*2^-46) - ref in Q8.8, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module slmb_log (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  slmb_pkg::power_t   value,
    input  logic signed [15:0] ref_offset_db,
    output logic               done,
    output slmb_pkg::level_t   result
);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_NORM = 3'd1;
    localparam logic [2:0] L_SQ   = 3'd2;
    localparam logic [2:0] L_MUL  = 3'd3;
    localparam logic [2:0] L_FIN  = 3'd4;

    localparam logic signed [23:0] LOG_BIAS  = 24'(slmb_pkg::PWR_FRAC * 65536);
    localparam logic signed [18:0] DB_SCALE  = 19'(slmb_pkg::DB_PER_LOG2_Q16);
    localparam logic [43:0]        ROUND_Q88 = 44'(2**23);
    localparam logic signed [21:0] SAT_HI    = 22'(32767);
    localparam logic signed [21:0] SAT_LO    = -22'sd32768;

    logic [2:0]              state_reg, state_next;
    logic [3:0]              step_reg, step_next;
    logic [63:0]             word_reg, word_next;
    logic [5:0]              lz_reg, lz_next;
    logic [31:0]             x_reg, x_next;
    logic [15:0]             frac_reg, frac_next;
    logic signed [42:0]      n_reg, n_next;
    slmb_pkg::level_t        res_reg, res_next;
    logic                    done_reg, done_next;

    logic [5:0]              sh;
    logic [63:0]             mask;
    logic [63:0]             sq;
    logic [32:0]             t;
    logic [5:0]              e;
    logic signed [23:0]      lval;
    logic                    neg;
    logic [42:0]             nmag;
    logic [43:0]             rsum;
    logic signed [20:0]      q;
    logic signed [21:0]      diff;

    assign done   = done_reg;
    assign result = res_reg;

    assign sh   = 6'd32 >> step_reg;
    assign mask = ~({64{1'b1}} >> sh);
    assign sq   = x_reg * x_reg;
    assign t    = sq[63:31];
    assign e    = 6'd63 - lz_reg;
    assign lval = $signed({2'b00, e, frac_reg}) - LOG_BIAS;
    assign neg  = n_reg[42];
    assign nmag = neg ? 43'(-n_reg) : 43'(n_reg);
    assign rsum = {1'b0, nmag} + ROUND_Q88;
    assign q    = neg ? -$signed({1'b0, rsum[43:24]}) : $signed({1'b0, rsum[43:24]});
    assign diff = 22'(q) - 22'(ref_offset_db);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        word_next  = word_reg;
        lz_next    = lz_reg;
        x_next     = x_reg;
        frac_next  = frac_reg;
        n_next     = n_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            L_IDLE: begin
                if (start) begin
                    word_next  = 64'(value) + 64'd1;
                    lz_next    = '0;
                    step_next  = '0;
                    state_next = L_NORM;
                end
            end
            L_NORM: begin
                if ((word_reg & mask) == '0) begin
                    word_next = word_reg << sh;
                    lz_next   = lz_reg + sh;
                end
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd5) begin
                    x_next     = word_next[63:32];
                    frac_next  = '0;
                    step_next  = '0;
                    state_next = L_SQ;
                end
            end
            L_SQ: begin
                if (t[32]) begin
                    x_next                    = t[32:1];
                    frac_next[4'd15 - step_reg] = 1'b1;
                end else begin
                    x_next = t[31:0];
                end
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15) begin
                    state_next = L_MUL;
                end
            end
            L_MUL: begin
                n_next     = lval * DB_SCALE;
                state_next = L_FIN;
            end
            L_FIN: begin
                if (diff > SAT_HI) begin
                    res_next = 16'sd32767;
                end else if (diff < SAT_LO) begin
                    res_next = -16'sd32768;
                end else begin
                    res_next = diff[15:0];
                end
                done_next  = 1'b1;
                state_next = L_IDLE;
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        lz_reg   <= lz_next;
        x_reg    <= x_next;
        frac_reg <= frac_next;
        n_reg    <= n_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

/* design/slmb_back.sv */
// ----------------------------------------------------------------------------
// slmb_back
// Processing sequencer: per-band state, lowpass, decimation, mean and levels.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sound_level_meter_bands_unit_macros.svh"

module slmb_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  slmb_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    input  slmb_pkg::item_t      q_item,
    output logic                 q_pop,
    output logic                 log_start,
    output slmb_pkg::power_t     log_value,
    input  logic                 log_done,
    input  slmb_pkg::level_t     log_result,
    output logic                 m_valid,
    input  logic                 m_ready,
    output slmb_pkg::result_t    m_result
);

    localparam int PW  = slmb_pkg::PWR_W;
    localparam int BW  = slmb_pkg::BAND_W;
    localparam int CW  = slmb_pkg::COUNT_W;
    localparam int HW  = slmb_pkg::PHASE_W;
    localparam int DCW = $clog2(PW);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PEAK     = 4'd1;
    localparam logic [3:0] S_LP1      = 4'd2;
    localparam logic [3:0] S_LP2      = 4'd3;
    localparam logic [3:0] S_LP3      = 4'd4;
    localparam logic [3:0] S_LP4      = 4'd5;
    localparam logic [3:0] S_LP5      = 4'd6;
    localparam logic [3:0] S_DEC      = 4'd7;
    localparam logic [3:0] S_DIV      = 4'd8;
    localparam logic [3:0] S_MEAN     = 4'd9;
    localparam logic [3:0] S_LOG_GO   = 4'd10;
    localparam logic [3:0] S_LOG_WAIT = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    localparam logic [1:0] SEL_LEVEL = 2'd0;
    localparam logic [1:0] SEL_PEAK  = 2'd1;
    localparam logic [1:0] SEL_MAX   = 2'd2;
    localparam logic [1:0] SEL_MEAN  = 2'd3;

    localparam logic [80:0] ROUND_Q30 = 81'(2**29);

    // per-band state
    slmb_pkg::power_t lpp_reg   [slmb_pkg::NUM_BANDS];
    slmb_pkg::power_t lpo_reg   [slmb_pkg::NUM_BANDS];
    slmb_pkg::power_t peak_reg  [slmb_pkg::NUM_BANDS];
    slmb_pkg::power_t max_reg   [slmb_pkg::NUM_BANDS];
    slmb_pkg::power_t mean_reg  [slmb_pkg::NUM_BANDS];
    logic [CW-1:0]    cnt_reg   [slmb_pkg::NUM_BANDS];
    logic [HW-1:0]    phase_reg [slmb_pkg::NUM_BANDS];

    logic [3:0]           state_reg, state_next;
    logic [BW-1:0]        band_reg, band_next;
    logic                 ok_reg, ok_next;
    slmb_pkg::power_t     x_reg, x_next;
    slmb_pkg::power_t     p_reg, p_next;
    logic                 emit_reg, emit_next;
    logic [56:0]          prod_reg, prod_next;
    logic [80:0]          acc_reg, acc_next;
    logic [50:0]          y1_reg, y1_next;
    logic [PW-1:0]        div_q_reg, div_q_next;
    logic [CW:0]          div_r_reg, div_r_next;
    logic [CW:0]          div_n1_reg, div_n1_next;
    logic                 div_neg_reg, div_neg_next;
    logic [DCW-1:0]       div_cnt_reg, div_cnt_next;
    logic [1:0]           log_sel_reg, log_sel_next;
    slmb_pkg::level_t     lvl_reg, lvl_next;
    slmb_pkg::level_t     pk_lvl_reg, pk_lvl_next;
    slmb_pkg::level_t     mx_lvl_reg, mx_lvl_next;
    slmb_pkg::level_t     eq_lvl_reg, eq_lvl_next;
    logic                 m_valid_reg, m_valid_next;
    slmb_pkg::result_t    out_reg, out_next;

    logic                 peak_we, max_we, mean_we, cnt_we, phase_we, lp_we;
    slmb_pkg::power_t     peak_wdata, max_wdata, mean_wdata;
    logic [CW-1:0]        cnt_wdata;
    logic [HW-1:0]        phase_wdata;

    slmb_pkg::power_t     cur_lpp, cur_lpo, cur_peak, cur_max, cur_mean;
    logic [CW-1:0]        cur_cnt;
    logic [HW-1:0]        cur_phase;

    logic [PW:0]          a_sum;
    logic [31:0]          a1_bits, a1m;
    logic [24:0]          mul_a;
    logic [31:0]          mul_b;
    logic [80:0]          lp_sum;
    logic [50:0]          y2;
    logic signed [52:0]   y_s;
    logic [HW-1:0]        ds;
    logic [HW:0]          ph1;
    logic [PW:0]          d;
    logic [PW-1:0]        dmag;
    logic [CW+1:0]        rs;
    logic [PW+1:0]        quo_ext, qv, mean_sum;
    logic                 out_free;

    assign cur_lpp   = lpp_reg[band_reg];
    assign cur_lpo   = lpo_reg[band_reg];
    assign cur_peak  = peak_reg[band_reg];
    assign cur_max   = max_reg[band_reg];
    assign cur_mean  = mean_reg[band_reg];
    assign cur_cnt   = cnt_reg[band_reg];
    assign cur_phase = phase_reg[band_reg];

    assign a_sum   = {1'b0, x_reg} + {1'b0, cur_lpp};
    assign a1_bits = cfg.lowpass_a1;
    assign a1m     = a1_bits[31] ? (~a1_bits + 32'd1) : a1_bits;
    assign lp_sum  = acc_reg + 81'(prod_reg) + ROUND_Q30;
    assign y2      = lp_sum[80:30];
    assign y_s     = a1_bits[31] ? ($signed({2'b00, y1_reg}) + $signed({2'b00, y2}))
                                 : ($signed({2'b00, y1_reg}) - $signed({2'b00, y2}));

    assign ds   = (cfg.ds_factor == '0) ? HW'(1) : cfg.ds_factor;
    assign ph1  = {1'b0, cur_phase} + (HW+1)'(1);
    assign d    = {1'b0, p_reg} - {1'b0, cur_mean};
    assign dmag = d[PW] ? PW'(~d + (PW+1)'(1)) : d[PW-1:0];
    assign rs   = {div_r_reg, div_q_reg[PW-1]};

    assign quo_ext  = {2'b00, div_q_reg};
    assign qv       = div_neg_reg ? (-quo_ext - (PW+2)'(div_r_reg != '0)) : quo_ext;
    assign mean_sum = {2'b00, cur_mean} + qv;

    assign out_free  = !m_valid_reg || m_ready;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign log_start = (state_reg == S_LOG_GO);
    assign m_valid   = m_valid_reg;
    assign m_result  = out_reg;

    always_comb begin
        unique case (log_sel_reg)
            SEL_LEVEL: log_value = p_reg;
            SEL_PEAK:  log_value = cur_peak;
            SEL_MAX:   log_value = cur_max;
            SEL_MEAN:  log_value = cur_mean;
            default:   log_value = p_reg;
        endcase
    end

    always_comb begin
        unique case (state_reg)
            S_LP1: begin
                mul_a = a_sum[PW:24];
                mul_b = {1'b0, cfg.lowpass_b0};
            end
            S_LP2: begin
                mul_a = {1'b0, a_sum[23:0]};
                mul_b = {1'b0, cfg.lowpass_b0};
            end
            S_LP3: begin
                mul_a = {1'b0, cur_lpo[PW-1:24]};
                mul_b = a1m;
            end
            default: begin
                mul_a = {1'b0, cur_lpo[23:0]};
                mul_b = a1m;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        band_next    = band_reg;
        ok_next      = ok_reg;
        x_next       = x_reg;
        p_next       = p_reg;
        emit_next    = emit_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        y1_next      = y1_reg;
        div_q_next   = div_q_reg;
        div_r_next   = div_r_reg;
        div_n1_next  = div_n1_reg;
        div_neg_next = div_neg_reg;
        div_cnt_next = div_cnt_reg;
        log_sel_next = log_sel_reg;
        lvl_next     = lvl_reg;
        pk_lvl_next  = pk_lvl_reg;
        mx_lvl_next  = mx_lvl_reg;
        eq_lvl_next  = eq_lvl_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        peak_we      = 1'b0;
        max_we       = 1'b0;
        mean_we      = 1'b0;
        cnt_we       = 1'b0;
        phase_we     = 1'b0;
        lp_we        = 1'b0;
        peak_wdata   = x_reg;
        max_wdata    = p_reg;
        mean_wdata   = mean_sum[PW-1:0];
        cnt_wdata    = (cur_cnt == '1) ? cur_cnt : cur_cnt + CW'(1);
        phase_wdata  = (ph1 >= {1'b0, ds}) ? '0 : ph1[HW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    band_next   = q_item.band;
                    ok_next     = q_item.band_ok;
                    x_next      = q_item.power;
                    emit_next   = 1'b0;
                    lvl_next    = '0;
                    pk_lvl_next = '0;
                    mx_lvl_next = '0;
                    eq_lvl_next = '0;
                    state_next  = S_PEAK;
                end
            end
            S_PEAK: begin
                if (!ok_reg) begin
                    state_next = S_DONE;
                end else begin
                    peak_we = (x_reg > cur_peak);
                    if (cfg.lowpass_enable) begin
                        state_next = S_LP1;
                    end else begin
                        p_next     = x_reg;
                        state_next = S_DEC;
                    end
                end
            end
            S_LP1: begin
                prod_next  = mul_a * mul_b;
                state_next = S_LP2;
            end
            S_LP2: begin
                acc_next   = {prod_reg, 24'b0};
                prod_next  = mul_a * mul_b;
                state_next = S_LP3;
            end
            S_LP3: begin
                y1_next    = y2;
                prod_next  = mul_a * mul_b;
                state_next = S_LP4;
            end
            S_LP4: begin
                acc_next   = {prod_reg, 24'b0};
                prod_next  = mul_a * mul_b;
                state_next = S_LP5;
            end
            S_LP5: begin
                if (y_s < 0) begin
                    p_next = '0;
                end else if (y_s[52:PW] != '0) begin
                    p_next = '1;
                end else begin
                    p_next = y_s[PW-1:0];
                end
                lp_we      = 1'b1;
                state_next = S_DEC;
            end
            S_DEC: begin
                phase_we = 1'b1;
                if (cur_phase == '0) begin
                    emit_next    = 1'b1;
                    max_we       = (p_reg > cur_max);
                    cnt_we       = 1'b1;
                    div_n1_next  = {1'b0, cur_cnt} + (CW+1)'(1);
                    div_neg_next = d[PW];
                    div_q_next   = dmag;
                    div_r_next   = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end else begin
                    log_sel_next = SEL_PEAK;
                    state_next   = S_LOG_GO;
                end
            end
            S_DIV: begin
                if (rs >= {1'b0, div_n1_reg}) begin
                    div_r_next = (CW+1)'(rs - {1'b0, div_n1_reg});
                    div_q_next = {div_q_reg[PW-2:0], 1'b1};
                end else begin
                    div_r_next = rs[CW:0];
                    div_q_next = {div_q_reg[PW-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(PW - 1)) begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN: begin
                mean_we      = 1'b1;
                log_sel_next = SEL_LEVEL;
                state_next   = S_LOG_GO;
            end
            S_LOG_GO: begin
                state_next = S_LOG_WAIT;
            end
            S_LOG_WAIT: begin
                if (log_done) begin
                    unique case (log_sel_reg)
                        SEL_LEVEL: lvl_next    = log_result;
                        SEL_PEAK:  pk_lvl_next = log_result;
                        SEL_MAX:   mx_lvl_next = log_result;
                        SEL_MEAN:  eq_lvl_next = log_result;
                        default:   lvl_next    = log_result;
                    endcase
                    if (log_sel_reg == SEL_MEAN) begin
                        state_next = S_DONE;
                    end else begin
                        log_sel_next = log_sel_reg + 2'd1;
                        state_next   = S_LOG_GO;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_next.band_out   = band_reg;
                    out_next.emitted    = emit_reg;
                    out_next.level      = lvl_reg;
                    out_next.peak_level = pk_lvl_reg;
                    out_next.max_level  = mx_lvl_reg;
                    out_next.eq_level   = eq_lvl_reg;
                    m_valid_next        = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        band_reg    <= band_next;
        ok_reg      <= ok_next;
        x_reg       <= x_next;
        p_reg       <= p_next;
        emit_reg    <= emit_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        y1_reg      <= y1_next;
        div_q_reg   <= div_q_next;
        div_r_reg   <= div_r_next;
        div_n1_reg  <= div_n1_next;
        div_neg_reg <= div_neg_next;
        div_cnt_reg <= div_cnt_next;
        log_sel_reg <= log_sel_next;
        lvl_reg     <= lvl_next;
        pk_lvl_reg  <= pk_lvl_next;
        mx_lvl_reg  <= mx_lvl_next;
        eq_lvl_reg  <= eq_lvl_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < slmb_pkg::NUM_BANDS; i++) begin
                lpp_reg[i]   <= '0;
                lpo_reg[i]   <= '0;
                peak_reg[i]  <= '0;
                max_reg[i]   <= '0;
                mean_reg[i]  <= '0;
                cnt_reg[i]   <= '0;
                phase_reg[i] <= '0;
            end
        end else begin
            if (peak_we) begin
                peak_reg[band_reg] <= peak_wdata;
            end
            if (lp_we) begin
                lpp_reg[band_reg] <= x_reg;
                lpo_reg[band_reg] <= p_next;
            end
            if (max_we) begin
                max_reg[band_reg] <= max_wdata;
            end
            if (mean_we) begin
                mean_reg[band_reg] <= mean_wdata;
            end
            if (cnt_we) begin
                cnt_reg[band_reg] <= cnt_wdata;
            end
            if (phase_we) begin
                phase_reg[band_reg] <= phase_wdata;
            end
        end
    end

    `SLMB_ASSERT_IMP(a_div_nonzero, aclk, aresetn, state_reg == S_DIV, div_n1_reg != '0, "divisor zero during mean update")
    `SLMB_ASSERT_IMP(a_log_done_wait, aclk, aresetn, log_done, state_reg == S_LOG_WAIT, "log result arrived outside wait state")
    `SLMB_ASSERT_NXT(a_out_load, aclk, aresetn, (state_reg == S_DONE) && out_free, m_valid_reg && (state_reg == S_IDLE), "result not loaded into output register")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Sound level meter bands unit testbench
// Drives band-tagged samples through the valid/ready input channel, predicts
// every result (power, lowpass, decimation, peak/max/mean, dB conversion) and
// checks each result transaction field by field across several register
// settings and idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import slmb_pkg::*;

class level_scoreboard;
    logic [15:0]        ds_factor;
    logic               lp_enable;
    logic [30:0]        lp_b0;
    logic signed [31:0] lp_a1;
    logic signed [15:0] ref_db;

    logic [63:0] prev_power [NUM_BANDS];
    logic [63:0] prev_output[NUM_BANDS];
    logic [63:0] peak_pwr   [NUM_BANDS];
    logic [63:0] max_pwr    [NUM_BANDS];
    logic [63:0] mean_pwr   [NUM_BANDS];
    logic [31:0] n_points   [NUM_BANDS];
    logic [15:0] phase      [NUM_BANDS];

    result_t pending[$];
    int      errors;
    int      checked;
    int      emits;

    function new();
        ds_factor = 1;
        lp_enable = 0;
        lp_b0     = 31'h4000_0000;
        lp_a1     = 0;
        ref_db    = 0;
        errors    = 0;
        checked   = 0;
        emits     = 0;
        for (int i = 0; i < NUM_BANDS; i++) begin
            prev_power[i] = 0; prev_output[i] = 0; peak_pwr[i] = 0;
            max_pwr[i] = 0; mean_pwr[i] = 0; n_points[i] = 0; phase[i] = 0;
        end
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            REG_DS_FACTOR:      ds_factor = v[15:0];
            REG_LOWPASS_ENABLE: lp_enable = v[0];
            REG_LOWPASS_B0:     lp_b0     = v[30:0];
            REG_LOWPASS_A1:     lp_a1     = v;
            REG_REF_OFFSET_DB:  ref_db    = v[15:0];
            default: ;
        endcase
    endfunction

    function logic [63:0] mul_q30(logic [63:0] a, logic [63:0] m);
        logic [127:0] prod;
        prod = a * m + (128'd1 << 29);
        return prod[93:30];
    endfunction

    function longint log2_q16(logic [63:0] v);
        int          e;
        logic [63:0] x;
        longint      r;
        e = 0;
        while (e < 63 && (v >> (e + 1)) != 0) e++;
        x = (e >= 31) ? (v >> (e - 31)) : (v << (31 - e));
        r = longint'(e) * 65536;
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 31;
            if (x >= (64'd1 << 32)) begin
                x = x >> 1;
                r += longint'(1) << (15 - i);
            end
        end
        return r;
    endfunction

    function logic [15:0] db_level(logic [63:0] p);
        longint l, n, q;
        l = log2_q16(p + 1) - longint'(PWR_FRAC) * 65536;
        n = l * DB_PER_LOG2_Q16;
        if (n >= 0) q = (n + (longint'(1) << 23)) >>> 24;
        else        q = -((-n + (longint'(1) << 23)) >>> 24);
        q = q - longint'(ref_db);
        if (q > 32767)  q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function void note_sample(logic [BAND_W-1:0] b, logic signed [SAMPLE_BITS-1:0] s);
        result_t     r;
        logic [63:0] mag, x, p, a1m;
        longint      y, d, q, n1;
        logic [15:0] ds;
        r = '0;
        r.band_out = b;
        ds  = (ds_factor == 0) ? 16'd1 : ds_factor;
        mag = (s < 0) ? 64'(-longint'(s)) : 64'(s);
        x   = mag * mag;
        if (x > peak_pwr[b]) peak_pwr[b] = x;
        if (lp_enable) begin
            a1m = (lp_a1 < 0) ? 64'(-longint'(lp_a1)) : 64'(lp_a1);
            y = longint'(mul_q30(x + prev_power[b], 64'(lp_b0)));
            if (lp_a1 < 0) y += longint'(mul_q30(prev_output[b], a1m));
            else           y -= longint'(mul_q30(prev_output[b], a1m));
            if (y < 0) y = 0;
            if (y > longint'(48'hFFFF_FFFF_FFFF)) y = longint'(48'hFFFF_FFFF_FFFF);
            p = 64'(y);
            prev_power[b]  = x;
            prev_output[b] = p;
        end else begin
            p = x;
        end
        if (phase[b] == 0) begin
            n1 = longint'(n_points[b]) + 1;
            d  = longint'(p) - longint'(mean_pwr[b]);
            q  = d / n1;
            if (d < 0 && q * n1 != d) q -= 1;
            mean_pwr[b] = 64'(longint'(mean_pwr[b]) + q);
            if (p > max_pwr[b]) max_pwr[b] = p;
            if (n_points[b] != 32'hFFFF_FFFF) n_points[b]++;
            r.emitted = 1'b1;
            r.level   = db_level(p);
        end
        phase[b] = (32'(phase[b]) + 1 >= 32'(ds)) ? 16'd0 : phase[b] + 16'd1;
        r.peak_level = db_level(peak_pwr[b]);
        r.max_level  = db_level(max_pwr[b]);
        r.eq_level   = db_level(mean_pwr[b]);
        pending.push_back(r);
    endfunction

    function void check_result(result_t got);
        result_t exp_r;
        checked++;
        if (pending.size() == 0) begin
            $error("unexpected result transaction, band %0d", got.band_out);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (exp_r.emitted) emits++;
        if (got.band_out !== exp_r.band_out) begin
            $error("band_out: expected %0d, got %0d", exp_r.band_out, got.band_out);
            errors++;
        end
        if (got.emitted !== exp_r.emitted) begin
            $error("emitted: expected %0d, got %0d", exp_r.emitted, got.emitted);
            errors++;
        end
        if (got.level !== exp_r.level) begin
            $error("level: expected %0d, got %0d", exp_r.level, got.level);
            errors++;
        end
        if (got.peak_level !== exp_r.peak_level) begin
            $error("peak_level: expected %0d, got %0d", exp_r.peak_level, got.peak_level);
            errors++;
        end
        if (got.max_level !== exp_r.max_level) begin
            $error("max_level: expected %0d, got %0d", exp_r.max_level, got.max_level);
            errors++;
        end
        if (got.eq_level !== exp_r.eq_level) begin
            $error("eq_level: expected %0d, got %0d", exp_r.eq_level, got.eq_level);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [CFG_ADDR_W-1:0]         cfg_addr;
    logic [CFG_DATA_W-1:0]         cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    logic [BAND_W-1:0]             s_band;
    logic signed [SAMPLE_BITS-1:0] s_sample;
    logic                          m_valid;
    logic                          m_ready;
    result_t                       m_res;

    level_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int sent;

    sound_level_meter_bands_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_band       (s_band),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_band_out   (m_res.band_out),
        .m_emitted    (m_res.emitted),
        .m_level      (m_res.level),
        .m_peak_level (m_res.peak_level),
        .m_max_level  (m_res.max_level),
        .m_eq_level   (m_res.eq_level)
    );

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_sample(s_band, s_sample);
            if (m_valid && m_ready) sb.check_result(m_res);
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    task automatic configure(logic [15:0] ds, logic en, logic [30:0] b0,
                             logic signed [31:0] a1, logic signed [15:0] ref_v);
        write_reg(REG_DS_FACTOR, 32'(ds));
        write_reg(REG_LOWPASS_ENABLE, 32'(en));
        write_reg(REG_LOWPASS_B0, 32'(b0));
        write_reg(REG_LOWPASS_A1, a1);
        write_reg(REG_REF_OFFSET_DB, 32'(unsigned'(ref_v)));
        write_reg(CFG_ADDR_W'($urandom_range(5, 7)), $urandom);
        cfg_we <= 1'b0;
    endtask

    task automatic send(logic [BAND_W-1:0] b, logic signed [SAMPLE_BITS-1:0] s);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_band   <= b;
        s_sample <= s;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0:       return 24'sh7F_FFFF;
            1:       return 24'sh80_0000;
            2:       return 24'sd0;
            3:       return 24'($signed($urandom_range(32)) - 16);
            4, 5:    return 24'($signed(r[23:0]) >>> $urandom_range(23));
            default: return r[23:0];
        endcase
    endfunction

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 84; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 84; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
        endcase
    endtask

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0) set_idling($urandom_range(3));
            send(BAND_W'($urandom_range(NUM_BANDS - 1)), pick_sample());
        end
    endtask

    initial begin
        sb = new();
        sent = 0;
        aresetn = 1'b0;
        cfg_we <= 1'b0; cfg_addr <= '0; cfg_wdata <= '0;
        s_valid <= 1'b0; s_band <= '0; s_sample <= '0;
        set_idling(0);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, zero on every band, then sample extremes on bands 0, 7, 1 and 2
        for (int b = 0; b < NUM_BANDS; b++) send(BAND_W'(b), 24'sd0);
        send(3'd0, 24'sh7F_FFFF);
        send(3'd7, 24'sh80_0000);
        send(3'd1, 24'sd1);
        send(3'd1, -24'sd1);
        send(3'd2, 24'sh55_5555);
        send(3'd2, 24'shAA_AAAA);
        drain();
        // zero decimation factor behaves as one, lowpass on
        configure(16'd0, 1'b1, 31'h4000_0000, -32'sh4000_0000, 16'sh7FFF);
        for (int i = 0; i < 6; i++) send(3'd3, i[0] ? 24'sh80_0000 : 24'sh7F_FFFF);
        drain();
        // large factor, then lowered so the phase lies beyond it
        configure(16'd65535, 1'b0, 31'd0, 32'sh4000_0000, -16'sh8000);
        for (int i = 0; i < 5; i++) send(3'd4, pick_sample());
        drain();
        configure(16'd2, 1'b1, 31'd0, 32'sh4000_0000, 16'sd0);
        for (int i = 0; i < 4; i++) send(3'd4, pick_sample());
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: configure(16'd1, 1'b0, 31'h4000_0000, 32'sd0, 16'sd0);
                1: configure(16'd3, 1'b1, 31'd12345, -32'sh3FFF_0000, 16'sd2560);
                2: configure(16'd2, 1'b1, 31'h4000_0000, -32'sh4000_0000, -16'sh8000);
                3: configure(16'd1, 1'b1, 31'h4000_0000, 32'sh4000_0000, 16'sh7FFF);
                4: configure(16'd5, 1'b0, 31'd0, 32'sd0, -16'sd1000);
                5: configure(16'd1, 1'b1, 31'($urandom), $signed(32'($urandom_range(0, 2**30)))
                             - 32'sh2000_0000, 16'($urandom));
                6: configure(16'd65535, 1'b1, 31'h0010_0000, -32'sh3FF0_0000, 16'sd0);
                default: configure(16'd0, 1'b1, 31'h0000_8000, -32'sh3FFF_8000, 16'sd300);
            endcase
            random_burst(210);
            drain();
        end

        $display("Sent %0d samples, checked %0d results, %0d at decimation points.",
                 sent, sb.checked, sb.emits);
        $display("Covered decimation factors 0 to 65535, lowpass on and off, offset extremes.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
